[hw/rtl/mlcd_pkg.sv]
// mlcd_pkg: shared types, codes and helpers for the memory lcd line controller
// no dependencies; used by every module of the block but mlcd_ram
`timescale 1ns / 1ps

package mlcd_pkg;

    // item kinds on the input channel
    localparam logic [2:0] KIND_DRAW         = 3'd0;
    localparam logic [2:0] KIND_DRAW_REFRESH = 3'd1;
    localparam logic [2:0] KIND_REFRESH      = 3'd2;
    localparam logic [2:0] KIND_CLEAR        = 3'd3;
    localparam logic [2:0] KIND_READ         = 3'd4;
    localparam logic [2:0] KIND_WRITE        = 3'd5;

    // panel link bytes
    localparam logic [7:0] CMD_UPDATE = 8'h80;
    localparam logic [7:0] CMD_CLEAR  = 8'h20;
    localparam logic [7:0] VCOM_FLAG  = 8'h40;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_WHITE = 8'hff;

    // store addresses, wide enough for 255 lines of 128 bytes
    localparam int CMD_ADDR_W = 15;

    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] pixel_x;
        logic [7:0] pixel_y;
        logic       draw_black;
        logic [5:0] byte_column;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_pixel_answer;
        logic       pixel_white;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_DRAW,
        OP_DRAW_REFRESH,
        OP_REFRESH,
        OP_CLEAR,
        OP_READ,
        OP_READ_WHITE,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CMD_ADDR_W-1:0] addr;
        logic [CMD_ADDR_W-1:0] base;
        logic [7:0]            mask;
        logic                  black;
        logic [7:0]            value;
        logic [7:0]            line_code;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } status_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_HDR,
        ST_LINE_NO,
        ST_DATA,
        ST_TRAIL0,
        ST_TRAIL1,
        ST_CLR_CMD,
        ST_CLR_ZERO,
        ST_READ,
        ST_WRITE
    } back_state_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[i];
        end
        return r;
    endfunction

endpackage

[hw/rtl/memory_lcd_line_controller.sv]
// memory_lcd_line_controller: top level of the 1-bit memory lcd line controller
// depends on mlcd_pkg, mlcd_front, mlcd_cmd_queue, mlcd_back, mlcd_ram
//
// items enter on s_valid/s_ready with an in_item_t payload; link bytes and pixel
// answers leave on m_valid/m_ready as out_item_t, with last on the final one of
// each item. cfg_wr_en/cfg_wr_data write mirror_mode (reset 1); the user is to
// write it only while idle, which the block does not enforce. the front takes
// one item per cycle while the command queue has room; items that produce no
// command (out of range draws, refreshes and writes, unused kinds) finish there.
// the back runs one command at a time from a single-port-per-direction frame ram:
// a line refresh streams 4 + (PIXELS_PER_LINE+7)/8 bytes, 54 for 400 pixels, one
// per cycle while the output fifo has room; a draw adds a read-modify-write; a
// clear emits 2 bytes and then rewrites all LINE_COUNT*(PIXELS_PER_LINE+7)/8 store
// bytes (12000 by default), one per cycle, before the next command starts. after
// reset the same fill pass runs with s_ready low. a stalled receiver backs up a
// 4-entry output fifo, then the back, then the command queue, and finally s_ready
// drops; nothing is lost.
`timescale 1ns / 1ps

module memory_lcd_line_controller #(
    parameter int PIXELS_PER_LINE = 400,
    parameter int LINE_COUNT      = 240
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  mlcd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mlcd_pkg::out_item_t m_item
);

    logic              fq_valid;
    logic              fq_ready;
    mlcd_pkg::cmd_t    fq_cmd;
    logic              qb_valid;
    logic              qb_ready;
    mlcd_pkg::cmd_t    qb_cmd;
    mlcd_pkg::status_t back_status;

    mlcd_front #(
        .PIXELS_PER_LINE(PIXELS_PER_LINE),
        .LINE_COUNT     (LINE_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_cmd      (fq_cmd),
        .status     (back_status)
    );

    mlcd_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_cmd   (fq_cmd),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_cmd  (qb_cmd)
    );

    mlcd_back #(
        .PIXELS_PER_LINE(PIXELS_PER_LINE),
        .LINE_COUNT     (LINE_COUNT)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(qb_valid),
        .q_ready(qb_ready),
        .q_cmd  (qb_cmd),
        .status (back_status),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

endmodule

[hw/rtl/mlcd_ram.sv]
// mlcd_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mlcd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/mlcd_front.sv]
// mlcd_front: accepts input items, checks ranges, mirrors coordinates and builds commands
// depends on mlcd_pkg
`timescale 1ns / 1ps

module mlcd_front #(
    parameter int PIXELS_PER_LINE = 400,
    parameter int LINE_COUNT      = 240
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  mlcd_pkg::in_item_t s_item,
    output logic              q_valid,
    input  logic              q_ready,
    output mlcd_pkg::cmd_t    q_cmd,
    input  mlcd_pkg::status_t status
);

    localparam int BPL = (PIXELS_PER_LINE + 7) / 8;
    localparam logic [10:0] PPL_C  = 11'(PIXELS_PER_LINE);
    localparam logic [7:0]  LINE_C = 8'(LINE_COUNT);
    localparam logic [7:0]  BPL_C  = 8'(BPL);

    logic        mirror_reg;
    logic        mirror_next;
    logic [10:0] x_ext;
    logic [10:0] x_phys;
    logic [7:0]  y_phys;
    logic        x_ok;
    logic        y_ok;
    logic        col_ok;
    logic        is_write;
    logic [7:0]  mul_y;
    logic [7:0]  col_sel;
    logic [mlcd_pkg::CMD_ADDR_W-1:0] base;
    logic        keep;
    mlcd_pkg::op_t op;

    assign mirror_next = cfg_wr_en ? cfg_wr_data : mirror_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg <= 1'b1;
        end else begin
            mirror_reg <= mirror_next;
        end
    end

    always_comb begin
        x_ext    = {2'b00, s_item.pixel_x};
        x_ok     = x_ext < PPL_C;
        y_ok     = s_item.pixel_y < LINE_C;
        col_ok   = {2'b00, s_item.byte_column} < BPL_C;
        x_phys   = mirror_reg ? (PPL_C - 11'd1 - x_ext) : x_ext;
        y_phys   = mirror_reg ? (LINE_C - 8'd1 - s_item.pixel_y) : s_item.pixel_y;
        is_write = s_item.kind == mlcd_pkg::KIND_WRITE;
        mul_y    = is_write ? s_item.pixel_y : y_phys;
        col_sel  = is_write ? {2'b00, s_item.byte_column} : x_phys[10:3];
        base     = mlcd_pkg::CMD_ADDR_W'(mul_y) * mlcd_pkg::CMD_ADDR_W'(BPL);
    end

    always_comb begin
        keep = 1'b0;
        op   = mlcd_pkg::OP_DRAW;
        case (s_item.kind)
            mlcd_pkg::KIND_DRAW: begin
                keep = x_ok && y_ok;
                op   = mlcd_pkg::OP_DRAW;
            end
            mlcd_pkg::KIND_DRAW_REFRESH: begin
                keep = x_ok && y_ok;
                op   = mlcd_pkg::OP_DRAW_REFRESH;
            end
            mlcd_pkg::KIND_REFRESH: begin
                keep = y_ok;
                op   = mlcd_pkg::OP_REFRESH;
            end
            mlcd_pkg::KIND_CLEAR: begin
                keep = 1'b1;
                op   = mlcd_pkg::OP_CLEAR;
            end
            mlcd_pkg::KIND_READ: begin
                keep = 1'b1;
                op   = (x_ok && y_ok) ? mlcd_pkg::OP_READ : mlcd_pkg::OP_READ_WHITE;
            end
            mlcd_pkg::KIND_WRITE: begin
                keep = col_ok && y_ok;
                op   = mlcd_pkg::OP_WRITE;
            end
            default: begin
                keep = 1'b0;
                op   = mlcd_pkg::OP_DRAW;
            end
        endcase
    end

    assign s_ready = q_ready && !status.init_busy;
    assign q_valid = s_valid && s_ready && keep;

    always_comb begin
        q_cmd.op        = op;
        q_cmd.base      = base;
        q_cmd.addr      = base + mlcd_pkg::CMD_ADDR_W'(col_sel);
        q_cmd.mask      = 8'h80 >> x_phys[2:0];
        q_cmd.black     = s_item.draw_black;
        q_cmd.value     = s_item.byte_value;
        q_cmd.line_code = mlcd_pkg::reverse8(y_phys + 8'd1);
    end

endmodule

[hw/rtl/mlcd_cmd_queue.sv]
// mlcd_cmd_queue: two-entry command queue between the front and back parts
// depends on mlcd_pkg
`timescale 1ns / 1ps

module mlcd_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mlcd_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output mlcd_pkg::cmd_t out_cmd
);

    mlcd_pkg::cmd_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[hw/rtl/mlcd_back.sv]
// mlcd_back: executes commands on the frame store and streams link bytes and answers
// depends on mlcd_pkg and mlcd_ram
`timescale 1ns / 1ps

module mlcd_back #(
    parameter int PIXELS_PER_LINE = 400,
    parameter int LINE_COUNT      = 240
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  mlcd_pkg::cmd_t     q_cmd,
    output mlcd_pkg::status_t  status,
    output logic               m_valid,
    input  logic               m_ready,
    output mlcd_pkg::out_item_t m_item
);

    localparam int BPL         = (PIXELS_PER_LINE + 7) / 8;
    localparam int STORE_BYTES = LINE_COUNT * BPL;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int COL_W       = (BPL > 1) ? $clog2(BPL) : 1;
    localparam int OFIFO_DEPTH = 4;
    localparam int OPTR_W      = 2;
    localparam int OCNT_W      = 3;
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_BYTES - 1);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(BPL - 1);
    localparam logic [OCNT_W-1:0] ISSUE_LIMIT = OCNT_W'(OFIFO_DEPTH - 1);
    localparam logic [OCNT_W-1:0] OFIFO_FULL  = OCNT_W'(OFIFO_DEPTH);

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_MEM_BYTE,
        SRC_MEM_PIXEL
    } emit_src_t;

    typedef struct packed {
        emit_src_t  src;
        logic [7:0] byte_val;
        logic       white;
        logic       ans;
        logic       last;
        logic [7:0] mask;
    } emit_t;

    mlcd_pkg::back_state_t st_reg;
    mlcd_pkg::back_state_t st_next;
    mlcd_pkg::cmd_t        cmd_reg;
    mlcd_pkg::cmd_t        cmd_next;
    logic                  vcom_reg;
    logic                  vcom_next;
    logic [ADDR_W-1:0]     fill_cnt_reg;
    logic [ADDR_W-1:0]     fill_cnt_next;
    logic                  fill_init_reg;
    logic                  fill_init_next;
    logic [COL_W-1:0]      col_cnt_reg;
    logic [COL_W-1:0]      col_cnt_next;
    logic                  em_valid_reg;
    logic                  em_valid_next;
    emit_t                 em_reg;
    emit_t                 em_next;
    emit_t                 em_new;

    mlcd_pkg::out_item_t   ofifo_mem_reg [OFIFO_DEPTH];
    logic [OPTR_W-1:0]     owr_ptr_reg;
    logic [OPTR_W-1:0]     ord_ptr_reg;
    logic [OCNT_W-1:0]     ocnt_reg;
    mlcd_pkg::out_item_t   push_item;
    logic                  pop;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [7:0]            ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [7:0]            ram_rdata;
    logic                  can_issue;
    logic                  issue;
    logic [7:0]            vcom_byte;

    mlcd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES),
        .ADDR_W(ADDR_W)
    ) u_frame_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign can_issue        = (ocnt_reg + OCNT_W'(em_valid_reg)) < ISSUE_LIMIT;
    assign vcom_byte        = (!vcom_reg) ? mlcd_pkg::VCOM_FLAG : mlcd_pkg::BYTE_ZERO;
    assign status.init_busy = fill_init_reg;

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            mlcd_pkg::ST_FILL: begin
                if (fill_cnt_reg == LAST_ADDR) begin
                    st_next = mlcd_pkg::ST_IDLE;
                end
            end
            mlcd_pkg::ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.op)
                        mlcd_pkg::OP_DRAW:         st_next = mlcd_pkg::ST_DRAW_RD;
                        mlcd_pkg::OP_DRAW_REFRESH: st_next = mlcd_pkg::ST_DRAW_RD;
                        mlcd_pkg::OP_REFRESH:      st_next = mlcd_pkg::ST_HDR;
                        mlcd_pkg::OP_CLEAR:        st_next = mlcd_pkg::ST_CLR_CMD;
                        mlcd_pkg::OP_READ:         st_next = mlcd_pkg::ST_READ;
                        mlcd_pkg::OP_READ_WHITE:   st_next = mlcd_pkg::ST_READ;
                        mlcd_pkg::OP_WRITE:        st_next = mlcd_pkg::ST_WRITE;
                        default:                   st_next = mlcd_pkg::ST_IDLE;
                    endcase
                end
            end
            mlcd_pkg::ST_DRAW_RD: st_next = mlcd_pkg::ST_DRAW_WR;
            mlcd_pkg::ST_DRAW_WR: begin
                st_next = (cmd_reg.op == mlcd_pkg::OP_DRAW_REFRESH) ?
                          mlcd_pkg::ST_HDR : mlcd_pkg::ST_IDLE;
            end
            mlcd_pkg::ST_HDR: begin
                if (can_issue) begin
                    st_next = mlcd_pkg::ST_LINE_NO;
                end
            end
            mlcd_pkg::ST_LINE_NO: begin
                if (can_issue) begin
                    st_next = mlcd_pkg::ST_DATA;
                end
            end
            mlcd_pkg::ST_DATA: begin
                if (can_issue && col_cnt_reg == LAST_COL) begin
                    st_next = mlcd_pkg::ST_TRAIL0;
                end
            end
            mlcd_pkg::ST_TRAIL0: begin
                if (can_issue) begin
                    st_next = mlcd_pkg::ST_TRAIL1;
                end
            end
            mlcd_pkg::ST_TRAIL1: begin
                if (can_issue) begin
                    st_next = mlcd_pkg::ST_IDLE;
                end
            end
            mlcd_pkg::ST_CLR_CMD: begin
                if (can_issue) begin
                    st_next = mlcd_pkg::ST_CLR_ZERO;
                end
            end
            mlcd_pkg::ST_CLR_ZERO: begin
                if (can_issue) begin
                    st_next = mlcd_pkg::ST_FILL;
                end
            end
            mlcd_pkg::ST_READ: begin
                if (can_issue) begin
                    st_next = mlcd_pkg::ST_IDLE;
                end
            end
            mlcd_pkg::ST_WRITE: st_next = mlcd_pkg::ST_IDLE;
            default:            st_next = mlcd_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_ready        = 1'b0;
        cmd_next       = cmd_reg;
        vcom_next      = vcom_reg;
        fill_cnt_next  = fill_cnt_reg;
        fill_init_next = fill_init_reg;
        col_cnt_next   = col_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(cmd_reg.addr);
        ram_wdata      = cmd_reg.value;
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(cmd_reg.addr);
        issue          = 1'b0;
        em_new.src      = SRC_CONST;
        em_new.byte_val = mlcd_pkg::BYTE_ZERO;
        em_new.white    = 1'b0;
        em_new.ans      = 1'b0;
        em_new.last     = 1'b0;
        em_new.mask     = cmd_reg.mask;
        case (st_reg)
            mlcd_pkg::ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = fill_cnt_reg;
                ram_wdata = mlcd_pkg::BYTE_WHITE;
                if (fill_cnt_reg == LAST_ADDR) begin
                    fill_cnt_next  = '0;
                    fill_init_next = 1'b0;
                end else begin
                    fill_cnt_next = fill_cnt_reg + ADDR_W'(1);
                end
            end
            mlcd_pkg::ST_IDLE: begin
                q_ready      = 1'b1;
                col_cnt_next = '0;
                if (q_valid) begin
                    cmd_next = q_cmd;
                end
            end
            mlcd_pkg::ST_DRAW_RD: begin
                ram_re = 1'b1;
            end
            mlcd_pkg::ST_DRAW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = cmd_reg.black ? (ram_rdata & ~cmd_reg.mask)
                                          : (ram_rdata | cmd_reg.mask);
            end
            mlcd_pkg::ST_HDR: begin
                issue           = can_issue;
                em_new.byte_val = mlcd_pkg::CMD_UPDATE | vcom_byte;
                if (can_issue) begin
                    vcom_next = ~vcom_reg;
                end
            end
            mlcd_pkg::ST_LINE_NO: begin
                issue           = can_issue;
                em_new.byte_val = cmd_reg.line_code;
            end
            mlcd_pkg::ST_DATA: begin
                issue      = can_issue;
                ram_re     = can_issue;
                ram_raddr  = ADDR_W'(cmd_reg.base) + ADDR_W'(col_cnt_reg);
                em_new.src = SRC_MEM_BYTE;
                if (can_issue) begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end
            mlcd_pkg::ST_TRAIL0: begin
                issue = can_issue;
            end
            mlcd_pkg::ST_TRAIL1: begin
                issue       = can_issue;
                em_new.last = 1'b1;
            end
            mlcd_pkg::ST_CLR_CMD: begin
                issue           = can_issue;
                em_new.byte_val = mlcd_pkg::CMD_CLEAR | vcom_byte;
                if (can_issue) begin
                    vcom_next = ~vcom_reg;
                end
            end
            mlcd_pkg::ST_CLR_ZERO: begin
                issue       = can_issue;
                em_new.last = 1'b1;
            end
            mlcd_pkg::ST_READ: begin
                issue       = can_issue;
                em_new.ans  = 1'b1;
                em_new.last = 1'b1;
                if (cmd_reg.op == mlcd_pkg::OP_READ_WHITE) begin
                    em_new.white = 1'b1;
                end else begin
                    ram_re     = can_issue;
                    em_new.src = SRC_MEM_PIXEL;
                end
            end
            mlcd_pkg::ST_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
        em_valid_next = issue;
        em_next       = issue ? em_new : em_reg;
    end

    // emit stage lands in the output fifo in the cycle after issue
    always_comb begin
        push_item.out_byte        = (em_reg.src == SRC_MEM_BYTE) ? ram_rdata : em_reg.byte_val;
        push_item.is_pixel_answer = em_reg.ans;
        push_item.pixel_white     = (em_reg.src == SRC_MEM_PIXEL) ?
                                    (|(ram_rdata & em_reg.mask)) : em_reg.white;
        push_item.last            = em_reg.last;
    end

    assign m_valid = ocnt_reg != '0;
    assign m_item  = ofifo_mem_reg[ord_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= mlcd_pkg::ST_FILL;
            vcom_reg      <= 1'b0;
            fill_cnt_reg  <= '0;
            fill_init_reg <= 1'b1;
            col_cnt_reg   <= '0;
            em_valid_reg  <= 1'b0;
            owr_ptr_reg   <= '0;
            ord_ptr_reg   <= '0;
            ocnt_reg      <= '0;
        end else begin
            st_reg        <= st_next;
            vcom_reg      <= vcom_next;
            fill_cnt_reg  <= fill_cnt_next;
            fill_init_reg <= fill_init_next;
            col_cnt_reg   <= col_cnt_next;
            em_valid_reg  <= em_valid_next;
            owr_ptr_reg   <= owr_ptr_reg + OPTR_W'(em_valid_reg);
            ord_ptr_reg   <= ord_ptr_reg + OPTR_W'(pop);
            ocnt_reg      <= ocnt_reg + OCNT_W'(em_valid_reg) - OCNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        em_reg  <= em_next;
        if (em_valid_reg) begin
            ofifo_mem_reg[owr_ptr_reg] <= push_item;
        end
    end

    a_ofifo_room: assert property (@(posedge aclk) disable iff (!aresetn)
        em_valid_reg |-> (ocnt_reg != OFIFO_FULL))
        else $error("output fifo overflow");

    a_ram_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("frame ram read and write in the same cycle");

    a_vcom_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (vcom_next != vcom_reg) |->
        (st_reg == mlcd_pkg::ST_HDR || st_reg == mlcd_pkg::ST_CLR_CMD))
        else $error("vcom changed outside a header");

    a_no_pop_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == mlcd_pkg::ST_FILL) |-> !q_ready)
        else $error("command taken during store fill");

    a_mem_read_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (em_valid_reg && em_reg.src != SRC_CONST) |-> $past(ram_re))
        else $error("store byte emitted without a read");

endmodule
